// ----- design/urc_pkg.sv -----
`default_nettype none

package urc_pkg;

	localparam int unsigned NUM_CHANNELS = 3;
	localparam int unsigned WIDTH_BITS   = 16;
	localparam int unsigned REG_BITS     = 16;
	localparam int unsigned INDEX_BITS   = 3;

	localparam logic [INDEX_BITS-1:0] REG_ENABLE          = 3'd0;
	localparam logic [INDEX_BITS-1:0] REG_TRIGGER_TICKS   = 3'd1;
	localparam logic [INDEX_BITS-1:0] REG_MEASURE_TIMEOUT = 3'd2;
	localparam logic [INDEX_BITS-1:0] REG_IDLE_TICKS      = 3'd3;
	localparam logic [INDEX_BITS-1:0] REG_NO_ECHO_VALUE   = 3'd4;

	localparam logic [REG_BITS-1:0] TRIGGER_TICKS_RST   = 16'd10;
	localparam logic [REG_BITS-1:0] MEASURE_TIMEOUT_RST = 16'hFFE0;
	localparam logic [REG_BITS-1:0] IDLE_TICKS_RST      = 16'hFFFE;
	localparam logic [REG_BITS-1:0] NO_ECHO_VALUE_RST   = 16'hFFFF;
	localparam logic [WIDTH_BITS-1:0] WIDTH_RST         = 16'hFFFF;

	typedef struct packed {
		logic                enable;
		logic [REG_BITS-1:0] trigger_ticks;
		logic [REG_BITS-1:0] measure_timeout;
		logic [REG_BITS-1:0] idle_ticks;
		logic [REG_BITS-1:0] no_echo_value;
	} cfg_t;

	typedef struct packed {
		logic                                     trigger_out;
		logic [NUM_CHANNELS-1:0][WIDTH_BITS-1:0]  width;
		logic                                     cycle_done;
		logic [NUM_CHANNELS-1:0]                  timeout_mask;
	} res_t;

endpackage

`default_nettype wire

// ----- design/urc_echo_if.sv -----
`default_nettype none

interface urc_echo_if;
	logic valid;
	logic ready;
	logic echo_a;
	logic echo_b;
	logic echo_c;

	modport source (output valid, output echo_a, output echo_b, output echo_c, input ready);
	modport sink (input valid, input echo_a, input echo_b, input echo_c, output ready);
endinterface

`default_nettype wire

// ----- design/urc_result_if.sv -----
`default_nettype none

interface urc_result_if;
	logic        valid;
	logic        ready;
	logic        trigger_out;
	logic [15:0] width_a;
	logic [15:0] width_b;
	logic [15:0] width_c;
	logic        cycle_done;
	logic [2:0]  timeout_mask;

	modport source (
		output valid, output trigger_out, output width_a, output width_b, output width_c,
		output cycle_done, output timeout_mask, input ready
	);
	modport sink (
		input valid, input trigger_out, input width_a, input width_b, input width_c,
		input cycle_done, input timeout_mask, output ready
	);
endinterface

`default_nettype wire

// ----- design/urc_cfg_regs.sv -----
`default_nettype none

module urc_cfg_regs (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire [urc_pkg::INDEX_BITS-1:0]  cfg_index,
	input  wire [urc_pkg::REG_BITS-1:0]    cfg_wdata,
	output urc_pkg::cfg_t                  cfg
);
	import urc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable          <= 1'b0;
			cfg_q.trigger_ticks   <= TRIGGER_TICKS_RST;
			cfg_q.measure_timeout <= MEASURE_TIMEOUT_RST;
			cfg_q.idle_ticks      <= IDLE_TICKS_RST;
			cfg_q.no_echo_value   <= NO_ECHO_VALUE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLE:          cfg_q.enable          <= cfg_wdata[0];
				REG_TRIGGER_TICKS:   cfg_q.trigger_ticks   <= cfg_wdata;
				REG_MEASURE_TIMEOUT: cfg_q.measure_timeout <= cfg_wdata;
				REG_IDLE_TICKS:      cfg_q.idle_ticks      <= cfg_wdata;
				REG_NO_ECHO_VALUE:   cfg_q.no_echo_value   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- design/urc_phase_engine.sv -----
`default_nettype none

module urc_phase_engine #(
	parameter int unsigned COUNT_BITS = 16
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              step,
	input  wire [urc_pkg::NUM_CHANNELS-1:0]  echo,
	input  urc_pkg::cfg_t                    cfg,
	output urc_pkg::res_t                    res
);
	import urc_pkg::*;

	localparam int unsigned CMP_BITS = (COUNT_BITS > REG_BITS) ? COUNT_BITS : REG_BITS;
	localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

	localparam logic [1:0] PH_DISABLED = 2'd0;
	localparam logic [1:0] PH_TRIGGER  = 2'd1;
	localparam logic [1:0] PH_MEASURE  = 2'd2;
	localparam logic [1:0] PH_IDLE     = 2'd3;

	logic [1:0]                                phase_q, phase_d, phase_cur;
	logic [COUNT_BITS-1:0]                     tick_q, tick_d, tick_cur, tick_inc;
	logic [NUM_CHANNELS-1:0][COUNT_BITS-1:0]   rise_time_q, rise_time_d;
	logic [NUM_CHANNELS-1:0]                   rise_seen_q, rise_seen_d;
	logic [NUM_CHANNELS-1:0]                   chan_ready_q, chan_ready_d;
	logic [NUM_CHANNELS-1:0]                   prev_echo_q;
	logic [NUM_CHANNELS-1:0][WIDTH_BITS-1:0]   width_q, width_d;
	logic [NUM_CHANNELS-1:0]                   tmask;
	logic [COUNT_BITS-1:0]                     start;
	logic                                      trig;
	logic                                      done;
	logic                                      at_max;
	logic                                      hit_trigger, hit_timeout, hit_idle;

	always_comb begin
		phase_cur = cfg.enable ? ((phase_q == PH_DISABLED) ? PH_TRIGGER : phase_q) : PH_DISABLED;
		tick_cur  = (cfg.enable && phase_q == PH_DISABLED) ? '0 : tick_q;
		at_max    = (tick_cur == CMAX);
		tick_inc  = at_max ? tick_cur : tick_cur + 1'b1;

		hit_trigger = (CMP_BITS'(tick_inc) >= CMP_BITS'(cfg.trigger_ticks)) || (tick_inc == CMAX);
		hit_timeout = (CMP_BITS'(tick_inc) >= CMP_BITS'(cfg.measure_timeout)) || (tick_inc == CMAX);
		hit_idle    = (CMP_BITS'(tick_inc) >= CMP_BITS'(cfg.idle_ticks)) || (tick_inc == CMAX);

		phase_d      = phase_cur;
		tick_d       = tick_cur;
		rise_time_d  = rise_time_q;
		rise_seen_d  = rise_seen_q;
		chan_ready_d = chan_ready_q;
		width_d      = width_q;
		tmask        = '0;
		trig         = 1'b0;
		done         = 1'b0;
		start        = '0;

		unique case (phase_cur)
			PH_TRIGGER: begin
				trig   = 1'b1;
				tick_d = tick_inc;
				if (hit_trigger) begin
					phase_d      = PH_MEASURE;
					tick_d       = '0;
					rise_time_d  = '0;
					rise_seen_d  = '0;
					chan_ready_d = '0;
				end
			end
			PH_MEASURE: begin
				tick_d = tick_inc;
				for (int i = 0; i < NUM_CHANNELS; i++) begin
					start = rise_seen_q[i] ? rise_time_q[i] : '0;
					if (echo[i] && !prev_echo_q[i]) begin
						rise_time_d[i] = tick_inc;
						rise_seen_d[i] = 1'b1;
					end else if (!echo[i] && prev_echo_q[i]) begin
						width_d[i]      = WIDTH_BITS'(COUNT_BITS'(tick_inc - start));
						chan_ready_d[i] = 1'b1;
					end
				end
				if (&chan_ready_d) begin
					done    = 1'b1;
					phase_d = PH_IDLE;
					tick_d  = '0;
				end else if (hit_timeout) begin
					for (int i = 0; i < NUM_CHANNELS; i++) begin
						if (!chan_ready_d[i]) begin
							width_d[i] = cfg.no_echo_value;
							tmask[i]   = 1'b1;
						end
					end
					done    = 1'b1;
					phase_d = PH_IDLE;
					tick_d  = '0;
				end
			end
			PH_IDLE: begin
				tick_d = tick_inc;
				if (hit_idle) begin
					phase_d = PH_TRIGGER;
					tick_d  = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_DISABLED;
			tick_q       <= '0;
			rise_time_q  <= '0;
			rise_seen_q  <= '0;
			chan_ready_q <= '0;
			prev_echo_q  <= '0;
			width_q      <= {NUM_CHANNELS{WIDTH_RST}};
		end else if (step) begin
			phase_q      <= phase_d;
			tick_q       <= tick_d;
			rise_time_q  <= rise_time_d;
			rise_seen_q  <= rise_seen_d;
			chan_ready_q <= chan_ready_d;
			prev_echo_q  <= echo;
			width_q      <= width_d;
		end
	end

	always_comb begin
		res.trigger_out  = trig;
		res.width        = width_d;
		res.cycle_done   = done;
		res.timeout_mask = tmask;
	end

endmodule

`default_nettype wire

// ----- design/ultrasonic_ranging_controller.sv -----
// Channel   Direction  Beat contents
// echo      in         echo_a, echo_b, echo_c: sampled echo levels for one tick
// result    out        trigger_out, width_a..width_c, cycle_done, timeout_mask
// cfg       in         cfg_we, cfg_index, cfg_wdata: register write, no read-back
//
// One echo beat is taken every cycle unless the result stalls; its result passes
// the input register and the result register. The phase counter and per-channel
// state update from the input register; the result register decouples both sides.
// A stalled result holds the input register, which then lowers echo.ready.
// Reset is asynchronous and active low and needs no clearing pass.
`default_nettype none

module ultrasonic_ranging_controller #(
	parameter int unsigned COUNT_BITS = 16
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire [urc_pkg::INDEX_BITS-1:0]  cfg_index,
	input  wire [urc_pkg::REG_BITS-1:0]    cfg_wdata,
	urc_echo_if.sink                       echo,
	urc_result_if.source                   result
);
	import urc_pkg::*;

	cfg_t                    cfg;
	res_t                    res_next;
	res_t                    res_q;
	logic                    res_valid_q;
	logic [NUM_CHANNELS-1:0] echo_s1;
	logic                    valid_s1;
	logic                    step;

	assign step       = valid_s1 && (!res_valid_q || result.ready);
	assign echo.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (echo.valid && echo.ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (echo.valid && echo.ready) begin
			echo_s1 <= {echo.echo_c, echo.echo_b, echo.echo_a};
		end
	end

	urc_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	urc_phase_engine #(
		.COUNT_BITS (COUNT_BITS)
	) u_phase_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.echo   (echo_s1),
		.cfg    (cfg),
		.res    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_next;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.trigger_out  = res_q.trigger_out;
	assign result.width_a      = res_q.width[0];
	assign result.width_b      = res_q.width[1];
	assign result.width_c      = res_q.width[2];
	assign result.cycle_done   = res_q.cycle_done;
	assign result.timeout_mask = res_q.timeout_mask;

endmodule

`default_nettype wire

// ----- design/urc_checker.sv -----
`default_nettype none

module urc_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire        trigger_out,
	input wire [15:0] width_a,
	input wire [15:0] width_b,
	input wire [15:0] width_c,
	input wire        cycle_done,
	input wire [2:0]  timeout_mask
);

	// A stalled result beat must hold its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(width_a) && $stable(width_b)
			&& $stable(width_c) && $stable(cycle_done) && $stable(timeout_mask))
		else $error("result beat changed while stalled");

	// Every accepted echo beat has a result pending once it has passed the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 out_valid)
		else $error("accepted beat produced no result");

	// A timeout can only be reported on the tick that ends the measurement.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (timeout_mask != 3'd0) |-> cycle_done)
		else $error("timeout mask without cycle_done");

	// The measurement never ends on a trigger tick.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(cycle_done && trigger_out))
		else $error("cycle_done during trigger");

endmodule

bind ultrasonic_ranging_controller urc_checker u_urc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (echo.valid),
	.in_ready     (echo.ready),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.trigger_out  (result.trigger_out),
	.width_a      (result.width_a),
	.width_b      (result.width_b),
	.width_c      (result.width_c),
	.cycle_done   (result.cycle_done),
	.timeout_mask (result.timeout_mask)
);

`default_nettype wire

// ----- bench/urc_tick_checker.sv -----
module urc_tick_checker
	import urc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [INDEX_BITS-1:0] cfg_index,
	input  logic [REG_BITS-1:0]   cfg_wdata,
	urc_echo_if                   echo,
	urc_result_if                 result,
	output int                    faults,
	output int                    pending
);

	typedef enum logic [1:0] {
		RANGE_OFF,
		RANGE_PULSE,
		RANGE_LISTEN,
		RANGE_REST
	} range_phase_e;

	localparam logic [15:0] COUNT_TOP = 16'hFFFF;

	logic                run_en;
	logic [REG_BITS-1:0] pulse_len;
	logic [REG_BITS-1:0] listen_limit;
	logic [REG_BITS-1:0] rest_len;
	logic [REG_BITS-1:0] silent_width;

	range_phase_e        phase;
	logic [15:0]         tick_cnt;
	logic [15:0]         rise_at [NUM_CHANNELS];
	logic                rise_seen [NUM_CHANNELS];
	logic                ch_ready [NUM_CHANNELS];
	logic                last_lvl [NUM_CHANNELS];
	logic [15:0]         held_width [NUM_CHANNELS];

	res_t                reports_due [$];
	res_t                want;

	function automatic void bump_count();
		if (tick_cnt != COUNT_TOP) begin
			tick_cnt = tick_cnt + 16'd1;
		end
	endfunction

	function automatic logic count_hit(input logic [15:0] limit);
		return (tick_cnt >= limit) || (tick_cnt == COUNT_TOP);
	endfunction

	// Advances the ranging state by one tick and returns the beat it produces.
	function automatic res_t ranging_tick(input logic [2:0] lvl);
		res_t        r;
		logic        all_in;
		logic [15:0] start;
		r = '0;
		if (!run_en) begin
			phase = RANGE_OFF;
		end else if (phase == RANGE_OFF) begin
			phase = RANGE_PULSE;
			tick_cnt = '0;
		end
		case (phase)
			RANGE_PULSE: begin
				r.trigger_out = 1'b1;
				bump_count();
				if (count_hit(pulse_len)) begin
					phase = RANGE_LISTEN;
					tick_cnt = '0;
					for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
						rise_seen[ch] = 1'b0;
						ch_ready[ch] = 1'b0;
						rise_at[ch] = '0;
					end
				end
			end
			RANGE_LISTEN: begin
				all_in = 1'b1;
				bump_count();
				for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
					if (lvl[ch] && !last_lvl[ch]) begin
						rise_at[ch] = tick_cnt;
						rise_seen[ch] = 1'b1;
					end else if (!lvl[ch] && last_lvl[ch]) begin
						start = rise_seen[ch] ? rise_at[ch] : 16'd0;
						held_width[ch] = tick_cnt - start;
						ch_ready[ch] = 1'b1;
					end
					if (!ch_ready[ch]) begin
						all_in = 1'b0;
					end
				end
				if (all_in) begin
					r.cycle_done = 1'b1;
					phase = RANGE_REST;
					tick_cnt = '0;
				end else if (count_hit(listen_limit)) begin
					for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
						if (!ch_ready[ch]) begin
							held_width[ch] = silent_width;
							r.timeout_mask[ch] = 1'b1;
						end
					end
					r.cycle_done = 1'b1;
					phase = RANGE_REST;
					tick_cnt = '0;
				end
			end
			RANGE_REST: begin
				bump_count();
				if (count_hit(rest_len)) begin
					phase = RANGE_PULSE;
					tick_cnt = '0;
				end
			end
			default: begin
			end
		endcase
		for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
			last_lvl[ch] = lvl[ch];
			r.width[ch] = held_width[ch];
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] exp_val,
			input logic [15:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			faults++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_en = 1'b0;
			pulse_len = TRIGGER_TICKS_RST;
			listen_limit = MEASURE_TIMEOUT_RST;
			rest_len = IDLE_TICKS_RST;
			silent_width = NO_ECHO_VALUE_RST;
			phase = RANGE_OFF;
			tick_cnt = '0;
			for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
				rise_at[ch] = '0;
				rise_seen[ch] = 1'b0;
				ch_ready[ch] = 1'b0;
				last_lvl[ch] = 1'b0;
				held_width[ch] = WIDTH_RST;
			end
			reports_due.delete();
			faults = 0;
			pending = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (reports_due.size() == 0) begin
					$error("result beat arrived with no tick outstanding");
					faults++;
				end else begin
					want = reports_due.pop_front();
					check_field("trigger_out", 16'(want.trigger_out), 16'(result.trigger_out));
					check_field("width_a", want.width[0], result.width_a);
					check_field("width_b", want.width[1], result.width_b);
					check_field("width_c", want.width[2], result.width_c);
					check_field("cycle_done", 16'(want.cycle_done), 16'(result.cycle_done));
					check_field("timeout_mask", 16'(want.timeout_mask),
						16'(result.timeout_mask));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_ENABLE:          run_en = cfg_wdata[0];
					REG_TRIGGER_TICKS:   pulse_len = cfg_wdata;
					REG_MEASURE_TIMEOUT: listen_limit = cfg_wdata;
					REG_IDLE_TICKS:      rest_len = cfg_wdata;
					REG_NO_ECHO_VALUE:   silent_width = cfg_wdata;
					default: begin
					end
				endcase
			end
			if (echo.valid && echo.ready) begin
				reports_due.push_back(ranging_tick({echo.echo_c, echo.echo_b, echo.echo_a}));
			end
			pending = reports_due.size();
		end
	end

endmodule

// ----- bench/ultrasonic_ranging_controller_tb.sv -----
module ultrasonic_ranging_controller_tb;
	import urc_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SEGMENTS = 20;
	localparam int SEGMENT_TICKS = 45;
	localparam int ZERO_TICKS = 30;
	localparam logic [2:0] OPENING_TICKS [20] = '{
		3'b111, 3'b111, 3'b110, 3'b100, 3'b101, 3'b100, 3'b000, 3'b000, 3'b000, 3'b000,
		3'b001, 3'b011, 3'b001, 3'b001, 3'b001, 3'b001, 3'b001, 3'b001, 3'b001, 3'b000
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [INDEX_BITS-1:0] cfg_index;
	logic [REG_BITS-1:0]   cfg_wdata;
	int                    gap_pct = 0;
	int                    stall_pct = 0;
	int                    faults;
	int                    pending;
	int                    cycles = 0;

	urc_echo_if   echo_ch ();
	urc_result_if result_ch ();

	ultrasonic_ranging_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.echo      (echo_ch),
		.result    (result_ch)
	);

	urc_tick_checker tick_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.echo      (echo_ch),
		.result    (result_ch),
		.faults    (faults),
		.pending   (pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Offers one tick beat, with random gaps beforehand, and returns at the
	// falling edge after it was taken.
	task automatic send_tick(input logic [2:0] lv);
		while ($urandom_range(0, 99) < gap_pct) begin
			echo_ch.valid <= 1'b0;
			@(negedge clk);
		end
		echo_ch.valid <= 1'b1;
		echo_ch.echo_a <= lv[0];
		echo_ch.echo_b <= lv[1];
		echo_ch.echo_c <= lv[2];
		@(posedge clk);
		while (!echo_ch.ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic drain_results();
		echo_ch.valid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic program_ranging(input logic en, input logic [15:0] trig,
			input logic [15:0] tmo, input logic [15:0] rest, input logic [15:0] silent);
		logic [REG_BITS-1:0] vals [5];
		logic [INDEX_BITS-1:0] regs [5];
		regs = '{REG_TRIGGER_TICKS, REG_MEASURE_TIMEOUT, REG_IDLE_TICKS,
			REG_NO_ECHO_VALUE, REG_ENABLE};
		vals = '{trig, tmo, rest, silent, {15'd0, en}};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= regs[i];
			cfg_wdata <= vals[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		logic [2:0] lv;
		logic       noise;
		echo_ch.valid = 1'b0;
		echo_ch.echo_a = 1'b0;
		echo_ch.echo_b = 1'b0;
		echo_ch.echo_c = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ENABLE;
		cfg_wdata = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Ticks while disabled must leave the reset widths in place.
		send_tick(3'b111);
		send_tick(3'b000);
		send_tick(3'b101);
		drain_results();

		// Falls with no rise, a rise after ready, completion and a timeout.
		program_ranging(1'b1, 16'd2, 16'd9, 16'd1, 16'd0);
		foreach (OPENING_TICKS[i]) begin
			send_tick(OPENING_TICKS[i]);
		end
		drain_results();

		// Every length at zero, so that each phase lasts a single tick.
		program_ranging(1'b1, 16'd0, 16'd0, 16'd0, 16'hFFFF);
		for (int i = 0; i < ZERO_TICKS; i++) begin
			send_tick({(i % 3) == 0, i < 12, (i >= 4) && (i < 20)});
		end
		drain_results();

		lv = 3'b000;
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg / 5)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct = 80;
					stall_pct = 0;
				end
				2: begin
					gap_pct = 0;
					stall_pct = 80;
				end
				default: begin
					gap_pct = 29;
					stall_pct = 29;
				end
			endcase
			drain_results();
			program_ranging($urandom_range(0, 5) != 0,
				($urandom_range(0, 4) == 0) ? 16'd1 : 16'($urandom_range(1, 5)),
				($urandom_range(0, 9) == 0) ? 16'd1 : 16'($urandom_range(3, 40)),
				16'($urandom_range(1, 6)),
				16'($urandom_range(0, 65535)));
			noise = ($urandom_range(0, 4) == 0);
			for (int k = 0; k < SEGMENT_TICKS; k++) begin
				if (noise) begin
					lv = 3'($urandom);
				end else begin
					for (int ch = 0; ch < 3; ch++) begin
						if ($urandom_range(0, 9) == 0) begin
							lv[ch] = ~lv[ch];
						end
					end
				end
				send_tick(lv);
			end
		end

		drain_results();
		repeat (10) @(negedge clk);
		if (faults == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
